@@ hdl/set_assoc_lru_cache_model_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the LRU cache model unit
// Concurrent checks clocked by clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SLCM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("slcm assertion failed");
`define SLCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcm assertion failed");
`else
`define SLCM_ASSERT_ALWAYS(label, expr)
`define SLCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/slcm_pkg.sv @@
// ----------------------------------------------------------------------------
// slcm_pkg
// Shared constants, command and status types and a saturating increment helper of the cache model.
// ----------------------------------------------------------------------------
package slcm_pkg;

  localparam int WAYS_DEF     = 8;
  localparam int MAX_SETS_DEF = 1024;

  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 48;
  localparam int BSZ_W        = 13;
  localparam int SCNT_W       = 11;
  localparam int CFG_W        = 13;
  localparam int SET_OUT_W    = 10;
  localparam int DIV_DIGITS   = 4;
  localparam int DIV_STEPS    = ADDR_W / DIV_DIGITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_SET_COUNT   = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic start_div2;
    logic mem_read;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

@@ hdl/slcm_div.sv @@
// ----------------------------------------------------------------------------
// slcm_div
// Restoring divider of a 64-bit dividend by a 13-bit divisor, four quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module slcm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [slcm_pkg::ADDR_W-1:0]       dividend,
  input  logic [slcm_pkg::BSZ_W-1:0]        divisor,
  output logic [slcm_pkg::ADDR_W-1:0]       quo,
  output logic [slcm_pkg::BSZ_W-1:0]        rem,
  output logic                              done
);

  logic                              busy_r;
  logic                              done_r;
  logic [slcm_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [slcm_pkg::ADDR_W-1:0]       q_r;
  logic [slcm_pkg::ADDR_W-1:0]       q_nxt;
  logic [slcm_pkg::BSZ_W-1:0]        r_r;
  logic [slcm_pkg::BSZ_W-1:0]        r_nxt;
  logic [slcm_pkg::BSZ_W-1:0]        dvs_r;

  always_comb begin
    logic [slcm_pkg::BSZ_W:0] t;
    q_nxt = q_r;
    r_nxt = r_r;
    for (int d = 0; d < slcm_pkg::DIV_DIGITS; d++) begin
      t = {r_nxt, q_nxt[slcm_pkg::ADDR_W-1]};
      q_nxt = {q_nxt[slcm_pkg::ADDR_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end
      r_nxt = t[slcm_pkg::BSZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == slcm_pkg::DIV_CNT_W'(slcm_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign quo  = q_r;
  assign rem  = r_r;
  assign done = done_r;

endmodule

@@ hdl/slcm_dp.sv @@
// ----------------------------------------------------------------------------
// slcm_dp
// Datapath: configuration registers, address divider, tag, age and per-set
// miss memories, LRU update, counters and output register.
// ----------------------------------------------------------------------------
module slcm_dp #(
  parameter int WAYS     = slcm_pkg::WAYS_DEF,
  parameter int MAX_SETS = slcm_pkg::MAX_SETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [slcm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [slcm_pkg::ADDR_W-1:0]       in_address,
  input  logic                              in_is_write,
  input  slcm_pkg::cmd_t                    cmd,
  output slcm_pkg::status_t                 st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_miss,
  output logic [slcm_pkg::SET_OUT_W-1:0]    out_set_index,
  output logic [slcm_pkg::CNT_W-1:0]        out_set_miss_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_access_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_read_hit_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_read_miss_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_write_hit_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_write_miss_count
);

  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int NSC   = (MAX_SETS < 2047) ? MAX_SETS : 2047;
  localparam int TROW  = WAYS * slcm_pkg::ADDR_W;
  localparam int AROW  = WAYS * AGE_W;

  logic [slcm_pkg::BSZ_W-1:0]   block_bytes_r;
  logic [slcm_pkg::SCNT_W-1:0]  set_count_r;
  logic [slcm_pkg::BSZ_W-1:0]   bsz;
  logic [slcm_pkg::SCNT_W-1:0]  nsets;

  logic                         is_write_r;
  logic [SW-1:0]                set_r;
  logic [SW-1:0]                set_w;
  logic [slcm_pkg::ADDR_W-1:0]  tag_r;
  logic [SW-1:0]                clr_cnt_r;

  logic                         div_start;
  logic [slcm_pkg::ADDR_W-1:0]  div_dvd;
  logic [slcm_pkg::BSZ_W-1:0]   div_dvs;
  logic [slcm_pkg::ADDR_W-1:0]  div_quo;
  logic [slcm_pkg::BSZ_W-1:0]   div_rem;
  logic                         div_done;

  logic [TROW-1:0]              tag_mem [MAX_SETS];
  logic [AROW-1:0]              age_mem [MAX_SETS];
  logic [slcm_pkg::CNT_W-1:0]   miss_mem [MAX_SETS];
  logic [TROW-1:0]              tag_rd_r;
  logic [AROW-1:0]              age_rd_r;
  logic [slcm_pkg::CNT_W-1:0]   miss_rd_r;

  logic                         mem_we;
  logic [SW-1:0]                mem_wa;
  logic [TROW-1:0]              tag_wd;
  logic [AROW-1:0]              age_wd;
  logic [slcm_pkg::CNT_W-1:0]   miss_wd;
  logic [TROW-1:0]              new_tags;
  logic [AROW-1:0]              new_ages;
  logic [AROW-1:0]              reset_ages;
  logic [slcm_pkg::CNT_W-1:0]   new_miss;
  logic                         hit;

  logic [slcm_pkg::CNT_W-1:0]   acc_cnt_r;
  logic [slcm_pkg::CNT_W-1:0]   rh_cnt_r;
  logic [slcm_pkg::CNT_W-1:0]   rm_cnt_r;
  logic [slcm_pkg::CNT_W-1:0]   wh_cnt_r;
  logic [slcm_pkg::CNT_W-1:0]   wm_cnt_r;
  logic                         res_miss_r;
  logic [slcm_pkg::CNT_W-1:0]   res_set_miss_r;
  logic                         out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= slcm_pkg::BSZ_W'(64);
      set_count_r   <= slcm_pkg::SCNT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        slcm_pkg::REG_BLOCK_BYTES: block_bytes_r <= cfg_wdata;
        slcm_pkg::REG_SET_COUNT:   set_count_r   <= cfg_wdata[slcm_pkg::SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bsz = (block_bytes_r == '0) ? slcm_pkg::BSZ_W'(1) : block_bytes_r;
    if (set_count_r == '0) begin
      nsets = slcm_pkg::SCNT_W'(1);
    end else if (set_count_r > slcm_pkg::SCNT_W'(NSC)) begin
      nsets = slcm_pkg::SCNT_W'(NSC);
    end else begin
      nsets = set_count_r;
    end
  end

  assign div_start = cmd.accept | cmd.start_div2;
  assign div_dvd   = cmd.accept ? in_address : div_quo;
  assign div_dvs   = cmd.accept ? bsz : slcm_pkg::BSZ_W'(nsets);
  assign set_w     = SW'(div_rem);

  slcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_write_r <= in_is_write;
    end
    if (cmd.mem_read) begin
      set_r <= set_w;
      tag_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    logic [AGE_W-1:0] pivot;
    logic [AGE_W-1:0] age;
    logic [WAYS-1:0]  match;
    for (int w = 0; w < WAYS; w++) begin
      reset_ages[w*AGE_W +: AGE_W] = AGE_W'(w);
      match[w] = (tag_rd_r[w*slcm_pkg::ADDR_W +: slcm_pkg::ADDR_W] == tag_r);
    end
    hit   = |match;
    pivot = AGE_W'(WAYS - 1);
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        pivot = age_rd_r[w*AGE_W +: AGE_W];
      end
    end
    new_tags = tag_rd_r;
    new_ages = age_rd_r;
    for (int w = 0; w < WAYS; w++) begin
      age = age_rd_r[w*AGE_W +: AGE_W];
      if (age < pivot) begin
        new_ages[w*AGE_W +: AGE_W] = age + 1'b1;
      end else if (age == pivot) begin
        new_ages[w*AGE_W +: AGE_W] = '0;
        new_tags[w*slcm_pkg::ADDR_W +: slcm_pkg::ADDR_W] = tag_r;
      end
    end
    new_miss = hit ? miss_rd_r : slcm_pkg::sat_inc(miss_rd_r);
  end

  assign mem_we  = cmd.clr_step | cmd.update;
  assign mem_wa  = cmd.clr_step ? clr_cnt_r : set_r;
  assign tag_wd  = cmd.clr_step ? '0 : new_tags;
  assign age_wd  = cmd.clr_step ? reset_ages : new_ages;
  assign miss_wd = cmd.clr_step ? '0 : new_miss;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa]  <= tag_wd;
      age_mem[mem_wa]  <= age_wd;
      miss_mem[mem_wa] <= miss_wd;
    end
    if (cmd.mem_read) begin
      tag_rd_r  <= tag_mem[set_w];
      age_rd_r  <= age_mem[set_w];
      miss_rd_r <= miss_mem[set_w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= '0;
      rh_cnt_r  <= '0;
      rm_cnt_r  <= '0;
      wh_cnt_r  <= '0;
      wm_cnt_r  <= '0;
    end else if (cmd.update) begin
      acc_cnt_r <= slcm_pkg::sat_inc(acc_cnt_r);
      if (is_write_r && hit) begin
        wh_cnt_r <= slcm_pkg::sat_inc(wh_cnt_r);
      end
      if (is_write_r && !hit) begin
        wm_cnt_r <= slcm_pkg::sat_inc(wm_cnt_r);
      end
      if (!is_write_r && hit) begin
        rh_cnt_r <= slcm_pkg::sat_inc(rh_cnt_r);
      end
      if (!is_write_r && !hit) begin
        rm_cnt_r <= slcm_pkg::sat_inc(rm_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_miss_r     <= !hit;
      res_set_miss_r <= new_miss;
    end
    if (cmd.load_out) begin
      out_miss             <= res_miss_r;
      out_set_index        <= slcm_pkg::SET_OUT_W'(set_r);
      out_set_miss_count   <= res_set_miss_r;
      out_access_count     <= acc_cnt_r;
      out_read_hit_count   <= rh_cnt_r;
      out_read_miss_count  <= rm_cnt_r;
      out_write_hit_count  <= wh_cnt_r;
      out_write_miss_count <= wm_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.clr_last = (clr_cnt_r == SW'(MAX_SETS - 1));
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

@@ hdl/slcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// slcm_ctrl
// Controller: sequences the clearing pass, both divisions, the set read,
// the LRU update and the hand-off to the output register.
// ----------------------------------------------------------------------------
module slcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slcm_pkg::status_t   st,
  output slcm_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIV1;
        end
      end
      S_DIV1: begin
        if (st.div_done) begin
          cmd.start_div2 = 1'b1;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (st.div_done) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ hdl/set_assoc_lru_cache_model_unit.sv @@
// ----------------------------------------------------------------------------
// Set-associative cache model with exact LRU ranks, hit/miss statistics.
// After reset the unit runs a clearing pass over all MAX_SETS entries of its
// set memories before it takes the first transaction. Accesses are then taken
// one at a time: the accept, two divisions (block number and set/tag split)
// of 16 steps each on a shared 4-bit-per-cycle divider, each followed by a
// step that hands back its done flag (the second of these also reads the
// set), the update and the load of the output register. A result waits in
// the output register while the next access is already being worked on; that
// access holds before its own load until the receiver has taken the result.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_unit_assert.svh"

module set_assoc_lru_cache_model_unit #(
  parameter int WAYS     = slcm_pkg::WAYS_DEF,
  parameter int MAX_SETS = slcm_pkg::MAX_SETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [slcm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [slcm_pkg::ADDR_W-1:0]       in_address,
  input  logic                              in_is_write,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_miss,
  output logic [slcm_pkg::SET_OUT_W-1:0]    out_set_index,
  output logic [slcm_pkg::CNT_W-1:0]        out_set_miss_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_access_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_read_hit_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_read_miss_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_write_hit_count,
  output logic [slcm_pkg::CNT_W-1:0]        out_write_miss_count
);

  slcm_pkg::cmd_t    cmd;
  slcm_pkg::status_t st;

  slcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  slcm_dp #(
    .WAYS     (WAYS),
    .MAX_SETS (MAX_SETS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_address           (in_address),
    .in_is_write          (in_is_write),
    .cmd                  (cmd),
    .st                   (st),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_miss             (out_miss),
    .out_set_index        (out_set_index),
    .out_set_miss_count   (out_set_miss_count),
    .out_access_count     (out_access_count),
    .out_read_hit_count   (out_read_hit_count),
    .out_read_miss_count  (out_read_miss_count),
    .out_write_hit_count  (out_write_hit_count),
    .out_write_miss_count (out_write_miss_count)
  );

  `SLCM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SLCM_ASSERT_ALWAYS(a_load_when_free, !cmd.load_out || st.out_free)
  `SLCM_ASSERT_NEXT(a_no_early_result, cmd.accept, !cmd.load_out && !cmd.update)
  `SLCM_ASSERT_ALWAYS(a_no_done_when_idle, !st.div_done || !in_ready)

endmodule
